// ===== rtl/lzss_stream_decompressor_unit_assert.svh =====
// Assertion macros used by the decompressor controller RTL.
// Simulation builds get checks; synthesis builds get empty bodies.
`ifndef LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property every clock while out of reset
`define LZSD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lzsd assertion failed");
// Check an overlapping implication every clock while out of reset
`define LZSD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzsd implication failed");
// Check a next-cycle implication every clock while out of reset
`define LZSD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzsd next-cycle check failed");
`else
`define LZSD_ASSERT(name, clk, rst_n, prop)
`define LZSD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LZSD_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lzsd_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// LZSS decompressor. No dependencies.
package lzsd_pkg;

  localparam int unsigned WIN_AW   = 12;
  localparam int unsigned WIN_SIZE = 4096;
  localparam int unsigned FILL_W   = WIN_AW + 1;
  localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;

  // Flag byte is held with a marker byte above it
  localparam logic [15:0] FLAG_MARK = 16'hFF00;
  // Copy counter holds match length minus one (2..17)
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] LEN_M1_BASE = 5'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       clear;     // restart stream: window empty, counters zero
    logic       hdr_wr;    // merge input word into the length header
    logic [1:0] hdr_idx;   // header byte lane
    logic       low_wr;    // capture first match word
    logic       lit;       // emit the input word as a literal
    logic       start;     // first window read of a match
    logic       issue;     // window read this cycle
    logic       emit_mem;  // emit the pending window read
    logic       last;      // emitted word is the last one for its input
  } lzsd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic hit;        // a word emitted now reaches the stream length
    logic tgt_zero;   // header value after this merge is zero
  } lzsd_sts_t;

endpackage

// ===== rtl/lzsd_ctrl.sv =====
// Parser and copy sequencer for the LZSS decompressor.
// Depends on lzsd_pkg and the assertion macro header.
`include "lzss_stream_decompressor_unit_assert.svh"
module lzsd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  input  logic               stream_start_i,
  output logic               in_stall_o,
  input  lzsd_pkg::lzsd_sts_t sts_i,
  output lzsd_pkg::lzsd_cmd_t cmd_o
);
  import lzsd_pkg::*;

  localparam logic [2:0] ST_HEADER = 3'd0;
  localparam logic [2:0] ST_FLAG   = 3'd1;
  localparam logic [2:0] ST_TOKEN  = 3'd2;
  localparam logic [2:0] ST_MATCH2 = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_COPY   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [1:0]       hidx_q, hidx_d;
  logic [15:0]      flag_q, flag_d;
  logic [CNT_W-1:0] left_q, left_d;

  logic       acc;
  logic [2:0] cur;
  logic [1:0] idx;
  logic [15:0] flag_sh;
  logic [2:0]  flag_nxt;

  // Hold input while a match copies or while the output is blocked
  assign in_stall_o = (state_q == ST_COPY) || !sts_i.out_free;
  assign acc        = in_valid_i && !in_stall_o;

  // Consume one flag bit; the marker tells when a new flag word is due
  assign flag_sh  = {1'b0, flag_q[15:1]};
  assign flag_nxt = flag_sh[8] ? ST_TOKEN : ST_FLAG;

  // Decode state and input into commands
  always_comb begin
    state_d = state_q;
    hidx_d  = hidx_q;
    flag_d  = flag_q;
    left_d  = left_q;
    cmd_o   = '0;
    cur     = stream_start_i ? ST_HEADER : state_q;
    idx     = stream_start_i ? 2'd0 : hidx_q;
    if (acc) begin
      cmd_o.clear = stream_start_i;
      if (stream_start_i) begin
        flag_d = '0;
      end
      unique case (cur)
        ST_HEADER: begin
          cmd_o.hdr_wr  = 1'b1;
          cmd_o.hdr_idx = idx;
          hidx_d        = idx + 2'd1;
          if (idx == 2'd3) begin
            state_d = sts_i.tgt_zero ? ST_DONE : ST_FLAG;
          end else begin
            state_d = ST_HEADER;
          end
        end
        ST_FLAG: begin
          flag_d  = FLAG_MARK | {8'd0, in_byte_i};
          state_d = ST_TOKEN;
        end
        ST_TOKEN: begin
          if (flag_q[0]) begin
            cmd_o.lit  = 1'b1;
            cmd_o.last = 1'b1;
            if (sts_i.hit) begin
              state_d = ST_DONE;
            end else begin
              flag_d  = flag_sh;
              state_d = flag_nxt;
            end
          end else begin
            cmd_o.low_wr = 1'b1;
            state_d      = ST_MATCH2;
          end
        end
        ST_MATCH2: begin
          cmd_o.start = 1'b1;
          cmd_o.issue = 1'b1;
          left_d      = {1'b0, in_byte_i[3:0]} + LEN_M1_BASE;
          state_d     = ST_COPY;
        end
        default: begin
          state_d = ST_DONE;
        end
      endcase
    end else if (state_q == ST_COPY && sts_i.out_free) begin
      // Emit one window word per cycle while the output is free and keep one read ahead
      cmd_o.emit_mem = 1'b1;
      cmd_o.last     = sts_i.hit || (left_q == '0);
      if (left_q != '0) begin
        cmd_o.issue = 1'b1;
        left_d      = left_q - 1'b1;
      end
      if (sts_i.hit) begin
        state_d = ST_DONE;
      end else if (left_q == '0) begin
        flag_d  = flag_sh;
        state_d = flag_nxt;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
      hidx_q  <= '0;
      flag_q  <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      hidx_q  <= hidx_d;
      flag_q  <= flag_d;
      left_q  <= left_d;
    end
  end

  `LZSD_ASSERT_IMP(a_emit_needs_room, clk_i, rst_ni, cmd_o.lit || cmd_o.emit_mem, sts_i.out_free)
  `LZSD_ASSERT(a_one_source, clk_i, rst_ni, !(cmd_o.lit && cmd_o.emit_mem))
  `LZSD_ASSERT_NXT(a_hit_ends, clk_i, rst_ni, (cmd_o.lit || cmd_o.emit_mem) && sts_i.hit, state_q == ST_DONE)
  `LZSD_ASSERT_IMP(a_copy_left, clk_i, rst_ni, state_q == ST_COPY, left_q <= 5'd17)

endmodule

// ===== rtl/lzsd_dpath.sv =====
// Window memory, length counters and output register of the LZSS
// decompressor. Depends on lzsd_pkg.
module lzsd_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_byte_i,
  input  lzsd_pkg::lzsd_cmd_t cmd_i,
  output lzsd_pkg::lzsd_sts_t sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o,
  output logic                stream_done_o
);
  import lzsd_pkg::*;

  logic [7:0]        win_mem [WIN_SIZE];
  logic [WIN_AW-1:0] wp_q, rd_addr_q, rd_addr;
  logic [FILL_W-1:0] fill_q;
  logic [31:0]       target_q, produced_q, tgt_base, tgt_new, prod_inc;
  logic [7:0]        low_q, rd_data_q, fwd_data_q, mem_byte, wdata;
  logic              ok_q, fwd_q, rd_ok, emit;
  logic [WIN_AW-1:0] rd_off;
  logic              out_valid_q, run_last_q, done_q;
  logic [7:0]        out_byte_q;

  // Merge a header word into the stream length
  assign tgt_base = cmd_i.clear ? 32'd0 : target_q;
  assign tgt_new  = tgt_base | ({24'd0, in_byte_i} << {cmd_i.hdr_idx, 3'b000});
  assign prod_inc = produced_q + 32'd1;

  // Window read address; an entry outside the written span reads as zero
  assign rd_addr = cmd_i.start ? {in_byte_i[7:4], low_q} : rd_addr_q;
  assign rd_off  = rd_addr - START_POS;
  assign rd_ok   = fill_q[WIN_AW] || ({1'b0, rd_off} < fill_q);

  // Pick the emitted word, forwarding a write that raced the read
  assign mem_byte = fwd_q ? fwd_data_q : (ok_q ? rd_data_q : 8'd0);
  assign emit     = cmd_i.lit || cmd_i.emit_mem;
  assign wdata    = cmd_i.lit ? in_byte_i : mem_byte;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.hit      = (prod_inc == target_q);
  assign sts_o.tgt_zero = (tgt_new == 32'd0);

  // Window memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (emit) begin
      win_mem[wp_q] <= wdata;
    end
    if (cmd_i.issue) begin
      rd_data_q <= win_mem[rd_addr];
    end
  end

  // Read side payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.low_wr) begin
      low_q <= in_byte_i;
    end
    if (cmd_i.issue) begin
      ok_q       <= rd_ok;
      fwd_q      <= emit && (rd_addr == wp_q);
      fwd_data_q <= wdata;
    end
  end

  // Stream counters and write pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= START_POS;
      fill_q     <= '0;
      target_q   <= '0;
      produced_q <= '0;
      rd_addr_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        wp_q       <= START_POS;
        fill_q     <= '0;
        produced_q <= '0;
        target_q   <= '0;
      end
      if (cmd_i.hdr_wr) begin
        target_q <= tgt_new;
      end
      if (emit) begin
        wp_q       <= wp_q + 1'b1;
        produced_q <= prod_inc;
        if (!fill_q[WIN_AW]) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.issue) begin
        rd_addr_q <= rd_addr + 1'b1;
      end
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= wdata;
      run_last_q <= cmd_i.last;
      done_q     <= sts_o.hit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign stream_done_o = done_q;

endmodule

// ===== rtl/lzss_stream_decompressor_unit.sv =====
// Top level of the LZSS stream decompressor (4096-byte window).
// Depends on lzsd_pkg, lzsd_ctrl and lzsd_dpath.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   in_byte_i, stream_start_i
//   out      source     out_valid_o/out_stall_i out_byte_o, run_last_o, stream_done_o
//
// Header, flag, literal and first match words are accepted without a copy phase.
// The second match word starts an L-word copy (3..18) that holds the input stalled;
// the window memory port gives one read and one write per cycle.
// Reset needs no clearing pass: a fill count marks the written window span.
// A stall on the output freezes the copy and holds the input stalled.
module lzss_stream_decompressor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_done_o
);
  import lzsd_pkg::*;

  lzsd_cmd_t cmd;
  lzsd_sts_t sts;

  // Parser and sequencer
  lzsd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_byte_i      (in_byte_i),
    .stream_start_i (stream_start_i),
    .in_stall_o     (in_stall_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // Window and output datapath
  lzsd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

endmodule
